// ----- rtl/sbus_channel_decoder_core_defines.svh -----
// ----------------------------------------------------------------------------
// SBUS channel decoder assertion macros
// Shared concurrent check forms, clocked on i_clk and held off in reset.
// ----------------------------------------------------------------------------
`ifndef SBUS_CHANNEL_DECODER_CORE_DEFINES_SVH
`define SBUS_CHANNEL_DECODER_CORE_DEFINES_SVH

// prop must hold at every edge out of reset
`define SBUSD_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// expr must never be true out of reset
`define SBUSD_NEVER(lbl, expr, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) !(expr)) else $error(msg);

`endif

// ----- rtl/sbusd_pkg.sv -----
// ----------------------------------------------------------------------------
// SBUS channel decoder package
// Field widths, frame constants, register indexes and the channel record.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package sbusd_pkg;

    localparam int RAW_W    = 11;
    localparam int GAIN_W   = 10;
    localparam int OFFSET_W = 12;
    localparam int VALUE_W  = 13;
    localparam int CHAN_W   = 4;
    localparam int ACC_W    = 18;
    localparam int HELD_W   = 5;
    localparam int SEEN_W   = 5;
    localparam int PROD_W   = RAW_W + GAIN_W;

    localparam logic [7:0]        SYNC_BYTE    = 8'h0F;
    localparam logic [HELD_W-1:0] RAW_BITS     = 5'd11;
    localparam logic [SEEN_W-1:0] DATA_BYTES   = 5'd22;
    localparam logic [CHAN_W-1:0] LAST_CHANNEL = 4'd15;

    // floor(x/1000) == (x*RECIP_MULT) >> RECIP_SHIFT, exact for x < 2^21
    localparam int               RECIP_SHIFT = 31;
    localparam int               RECIP_W     = 22;
    localparam logic [RECIP_W-1:0] RECIP_MULT = 22'd2147484;
    localparam int               QPROD_W     = PROD_W + RECIP_W;

    localparam logic [GAIN_W-1:0]   GAIN_RESET   = 10'd753;
    localparam logic [OFFSET_W-1:0] OFFSET_RESET = 12'd757;

    typedef enum logic [1:0] {
        CFG_ENABLE = 2'd0,
        CFG_GAIN   = 2'd1,
        CFG_OFFSET = 2'd2,
        CFG_SPARE  = 2'd3
    } t_cfg_index;

    typedef struct packed {
        logic              last;
        logic [CHAN_W-1:0] idx;
        logic [RAW_W-1:0]  raw;
    } t_chan;

endpackage

`default_nettype wire

// ----- rtl/sbusd_unpack.sv -----
// ----------------------------------------------------------------------------
// SBUS frame unpacker
// Tracks the frame, gathers data bytes LSB-first and registers each 11-bit
// channel as it completes.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "sbus_channel_decoder_core_defines.svh"

module sbusd_unpack (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_accept,
    input  wire logic [7:0]          i_byte,
    input  wire logic                i_start,
    input  wire logic                i_enable,
    input  wire logic                i_drain,
    output logic                     o_valid,
    output sbusd_pkg::t_chan         o_chan
);

    logic                            r_in_frame, n_in_frame;
    logic [sbusd_pkg::SEEN_W-1:0]    r_seen, n_seen;
    logic [sbusd_pkg::ACC_W-1:0]     r_acc, n_acc;
    logic [sbusd_pkg::HELD_W-1:0]    r_held, n_held;
    logic [sbusd_pkg::CHAN_W-1:0]    r_next, n_next;
    logic                            r_valid;
    sbusd_pkg::t_chan                r_chan;

    logic                            emit;
    sbusd_pkg::t_chan                chan;
    logic [sbusd_pkg::ACC_W-1:0]     acc_or;
    logic [sbusd_pkg::HELD_W-1:0]    held_sum;
    logic [sbusd_pkg::SEEN_W-1:0]    seen_inc;

    always_comb begin
        n_in_frame = r_in_frame;
        n_seen     = r_seen;
        n_acc      = r_acc;
        n_held     = r_held;
        n_next     = r_next;
        emit       = 1'b0;
        acc_or     = r_acc | (sbusd_pkg::ACC_W'(i_byte) << r_held[3:0]);
        held_sum   = r_held + 5'd8;
        seen_inc   = r_seen + 5'd1;
        chan.raw   = acc_or[sbusd_pkg::RAW_W-1:0];
        chan.idx   = r_next;
        chan.last  = (r_next == sbusd_pkg::LAST_CHANNEL);

        if (i_accept && i_enable) begin
            if (i_start) begin
                n_in_frame = (i_byte == sbusd_pkg::SYNC_BYTE);
                n_seen     = '0;
                n_acc      = '0;
                n_held     = '0;
                n_next     = '0;
            end else if (r_in_frame) begin
                n_seen = seen_inc;
                if (seen_inc >= sbusd_pkg::DATA_BYTES) begin
                    n_in_frame = 1'b0;
                end
                if (held_sum >= sbusd_pkg::RAW_BITS) begin
                    emit   = 1'b1;
                    n_acc  = acc_or >> sbusd_pkg::RAW_W;
                    n_held = held_sum - sbusd_pkg::RAW_BITS;
                    n_next = r_next + 4'd1;
                end else begin
                    n_acc  = acc_or;
                    n_held = held_sum;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_frame <= 1'b0;
            r_seen     <= '0;
            r_acc      <= '0;
            r_held     <= '0;
            r_next     <= '0;
            r_valid    <= 1'b0;
        end else begin
            r_in_frame <= n_in_frame;
            r_seen     <= n_seen;
            r_acc      <= n_acc;
            r_held     <= n_held;
            r_next     <= n_next;
            // a new beat replaces the stage; otherwise empty it once passed on
            if (i_accept) begin
                r_valid <= emit;
            end else if (i_drain) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_accept) begin
            r_chan <= chan;
        end
    end

    assign o_valid = r_valid;
    assign o_chan  = r_chan;

    `SBUSD_NEVER(a_held_range, r_held > 5'd10, "bit count above ten between beats")
    `SBUSD_ASSERT(a_frame_bytes,
        r_in_frame |-> r_seen < sbusd_pkg::DATA_BYTES,
        "open frame past its data bytes")
    `SBUSD_ASSERT(a_last_closes,
        (r_valid && r_chan.last) |-> (!r_in_frame && r_seen == sbusd_pkg::DATA_BYTES),
        "last channel without a closed frame")

endmodule

`default_nettype wire

// ----- rtl/sbusd_scale.sv -----
// ----------------------------------------------------------------------------
// SBUS channel scaler
// Two stages: raw times gain, then divide by 1000 through a reciprocal
// product and add the offset into the output register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module sbusd_scale (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_valid,
    input  wire sbusd_pkg::t_chan                i_chan,
    input  wire logic [sbusd_pkg::GAIN_W-1:0]    i_gain,
    input  wire logic [sbusd_pkg::OFFSET_W-1:0]  i_offset,
    input  wire logic                            i_out_ready,
    output logic                                 o_ready,
    output logic                                 o_valid,
    output logic [sbusd_pkg::CHAN_W-1:0]         o_idx,
    output logic [sbusd_pkg::VALUE_W-1:0]        o_value,
    output logic                                 o_last
);

    logic                               r_v2, r_v3;
    logic [sbusd_pkg::PROD_W-1:0]       r_prod;
    logic [sbusd_pkg::CHAN_W-1:0]       r_idx2, r_idx3;
    logic                               r_last2, r_last3;
    logic [sbusd_pkg::VALUE_W-1:0]      r_value;

    logic                               ready2, ready3;
    logic [sbusd_pkg::QPROD_W-1:0]      qprod;
    logic [sbusd_pkg::VALUE_W-1:0]      quot;

    assign ready3 = !r_v3 || i_out_ready;
    assign ready2 = !r_v2 || ready3;

    assign qprod = sbusd_pkg::QPROD_W'(r_prod) * sbusd_pkg::QPROD_W'(sbusd_pkg::RECIP_MULT);
    assign quot  = sbusd_pkg::VALUE_W'(qprod >> sbusd_pkg::RECIP_SHIFT);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            if (ready2) begin
                r_v2 <= i_valid;
            end
            if (ready3) begin
                r_v3 <= r_v2;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (ready2) begin
            r_prod  <= sbusd_pkg::PROD_W'(i_chan.raw) * sbusd_pkg::PROD_W'(i_gain);
            r_idx2  <= i_chan.idx;
            r_last2 <= i_chan.last;
        end
        if (ready3) begin
            r_value <= quot + sbusd_pkg::VALUE_W'(i_offset);
            r_idx3  <= r_idx2;
            r_last3 <= r_last2;
        end
    end

    assign o_ready = ready2;
    assign o_valid = r_v3;
    assign o_idx   = r_idx3;
    assign o_value = r_value;
    assign o_last  = r_last3;

endmodule

`default_nettype wire

// ----- rtl/sbus_channel_decoder_core.sv -----
// Pipeline: three register stages; m_axis_tvalid rises once a channel has passed the
// unpack, gain product and output registers after the byte completing it is accepted.
// Throughput: one byte beat per cycle while m_axis_tready does not hold the pipeline back; the
// three-stage pipeline (unpack, gain product, reciprocal divide and offset) advances whenever the output drains.
// Reset (i_rst_n low, synchronous): frame closed, pipeline empty, decoding
// disabled, gain 753 and offset 757.
// ----------------------------------------------------------------------------
// SBUS channel decoder core
// Byte stream in, scaled 16-channel values out, plus a register write port.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module sbus_channel_decoder_core (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         s_axis_tvalid,
    output logic              s_axis_tready,
    input  wire logic [7:0]   s_axis_tdata,   // [7:0] rx_byte
    input  wire logic [0:0]   s_axis_tuser,   // [0] frame_start
    output logic              m_axis_tvalid,
    input  wire logic         m_axis_tready,
    output logic [15:0]       m_axis_tdata,   // [12:0] channel_value, [15:13] zero
    output logic [3:0]        m_axis_tuser,   // [3:0] channel_index
    output logic              m_axis_tlast,   // last_channel
    input  wire logic         i_cfg_valid,
    output logic              o_cfg_ready,
    input  wire logic [1:0]   i_cfg_index,
    input  wire logic [11:0]  i_cfg_data
);

    logic                                r_enable;
    logic [sbusd_pkg::GAIN_W-1:0]        r_gain;
    logic [sbusd_pkg::OFFSET_W-1:0]      r_offset;

    logic                                accept;
    logic                                s1_valid;
    sbusd_pkg::t_chan                    s1_chan;
    logic                                s2_ready;
    logic [sbusd_pkg::VALUE_W-1:0]       out_value;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_enable <= 1'b0;
            r_gain   <= sbusd_pkg::GAIN_RESET;
            r_offset <= sbusd_pkg::OFFSET_RESET;
        end else if (i_cfg_valid) begin
            unique case (sbusd_pkg::t_cfg_index'(i_cfg_index))
                sbusd_pkg::CFG_ENABLE: r_enable <= i_cfg_data[0];
                sbusd_pkg::CFG_GAIN:   r_gain   <= i_cfg_data[sbusd_pkg::GAIN_W-1:0];
                sbusd_pkg::CFG_OFFSET: r_offset <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // stage one loads whenever it is empty or its content moves on
    assign s_axis_tready = !s1_valid || s2_ready;
    assign accept        = s_axis_tvalid && s_axis_tready;

    sbusd_unpack u_unpack (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (accept),
        .i_byte   (s_axis_tdata),
        .i_start  (s_axis_tuser[0]),
        .i_enable (r_enable),
        .i_drain  (s2_ready),
        .o_valid  (s1_valid),
        .o_chan   (s1_chan)
    );

    sbusd_scale u_scale (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (s1_valid),
        .i_chan      (s1_chan),
        .i_gain      (r_gain),
        .i_offset    (r_offset),
        .i_out_ready (m_axis_tready),
        .o_ready     (s2_ready),
        .o_valid     (m_axis_tvalid),
        .o_idx       (m_axis_tuser),
        .o_value     (out_value),
        .o_last      (m_axis_tlast)
    );

    assign m_axis_tdata = {3'b000, out_value};

endmodule

`default_nettype wire
